@@ hdl/lcts_pkg.sv @@
// Shared constants, codes and types for the load cell tare and scale block.
`default_nettype none

package lcts_pkg;

    localparam int RAW_W           = 24;
    localparam int SAMPLE_BITS     = 24;
    localparam int SCALE_FRAC_BITS = 24;
    localparam int SCALE_W         = 48;
    localparam int REF_W           = 24;
    localparam int WEIGHT_W        = 32;

    localparam int DELTA_W = SAMPLE_BITS + 1;
    localparam int PROD_W  = DELTA_W + SCALE_W;
    localparam int MQ_W    = PROD_W - SCALE_FRAC_BITS;
    localparam int DIVD_W  = REF_W + SCALE_FRAC_BITS;
    localparam int DQ_W    = (DIVD_W > SCALE_W) ? DIVD_W : SCALE_W;
    localparam int CNT_MAX = (DIVD_W > DELTA_W) ? DIVD_W : DELTA_W;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    localparam logic [1:0] ACT_MEASURE = 2'd0;
    localparam logic [1:0] ACT_TARE    = 2'd1;
    localparam logic [1:0] ACT_CALIB   = 2'd2;

    localparam logic [1:0] ST_MEASURED = 2'd0;
    localparam logic [1:0] ST_TARED    = 2'd1;
    localparam logic [1:0] ST_SCALED   = 2'd2;
    localparam logic [1:0] ST_REFUSED  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_RUN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic prep;
        logic step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic iter_done;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ hdl/lcts_dp.sv @@
// Datapath: tare and scale state, shift-add multiplier, restoring divider, result register.
`default_nettype none

module lcts_dp
    import lcts_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_stat                   o_stat,
    input  wire  [1:0]                 i_action,
    input  wire  [RAW_W-1:0]           i_raw_sample,
    input  wire  signed [REF_W-1:0]    i_reference_grams,
    output logic signed [WEIGHT_W-1:0] o_weight_grams,
    output logic [1:0]                 o_status,
    output logic                       o_saturated
);

    logic [1:0]                r_act;
    logic signed [SAMPLE_BITS-1:0] r_raw;
    logic signed [REF_W-1:0]   r_ref;
    logic signed [SAMPLE_BITS-1:0] r_tare;
    logic signed [SCALE_W-1:0] r_scale;
    logic                      r_neg;
    logic                      r_dzero;
    logic [DELTA_W-1:0]        r_mplier;
    logic [SCALE_W-1:0]        r_mcand;
    logic [PROD_W-1:0]         r_acc;
    logic [DELTA_W-1:0]        r_divisor;
    logic [DELTA_W-1:0]        r_rem;
    logic [DIVD_W-1:0]         r_quo;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [WEIGHT_W-1:0] r_weight;
    logic [1:0]                r_status;
    logic                      r_sat;

    logic                      w_is_tare;
    logic                      w_is_cal;
    logic signed [DELTA_W-1:0] w_delta;
    logic [DELTA_W-1:0]        w_dmag;
    logic [SCALE_W-1:0]        w_smag;
    logic [REF_W-1:0]          w_rmag;
    logic                      w_dzero;
    logic [DELTA_W:0]          w_rsh;
    logic [DELTA_W:0]          w_rsub;
    logic [MQ_W-1:0]           w_mq;
    logic [MQ_W-1:0]           w_mlim;
    logic                      w_msat;
    logic [MQ_W-1:0]           w_mclamp;
    logic [WEIGHT_W-1:0]       w_weight;
    logic [DQ_W-1:0]           w_dq;
    logic [DQ_W-1:0]           w_dlim;
    logic                      w_dsat;
    logic [DQ_W-1:0]           w_dclamp;
    logic [SCALE_W-1:0]        w_scale_new;

    always_comb begin
        w_is_tare = (r_act == ACT_TARE);
        w_is_cal  = (r_act == ACT_CALIB);
        w_delta   = {r_raw[SAMPLE_BITS-1], r_raw} - {r_tare[SAMPLE_BITS-1], r_tare};
        w_dmag    = w_delta[DELTA_W-1] ? DELTA_W'(-w_delta) : DELTA_W'(w_delta);
        w_smag    = r_scale[SCALE_W-1] ? SCALE_W'(-r_scale) : SCALE_W'(r_scale);
        w_rmag    = r_ref[REF_W-1] ? REF_W'(-r_ref) : REF_W'(r_ref);
        w_dzero   = (w_delta == '0);

        w_rsh  = {r_rem, r_quo[DIVD_W-1]};
        w_rsub = w_rsh - {1'b0, r_divisor};

        w_mq     = r_acc[PROD_W-1:SCALE_FRAC_BITS];
        w_mlim   = MQ_W'({r_neg, {(WEIGHT_W-1){~r_neg}}});
        w_msat   = (w_mq > w_mlim);
        w_mclamp = w_msat ? w_mlim : w_mq;
        w_weight = r_neg ? (~w_mclamp[WEIGHT_W-1:0] + 1'b1) : w_mclamp[WEIGHT_W-1:0];

        w_dq        = DQ_W'(r_quo);
        w_dlim      = DQ_W'({r_neg, {(SCALE_W-1){~r_neg}}});
        w_dsat      = (w_dq > w_dlim);
        w_dclamp    = w_dsat ? w_dlim : w_dq;
        w_scale_new = r_neg ? (~w_dclamp[SCALE_W-1:0] + 1'b1) : w_dclamp[SCALE_W-1:0];
    end

    assign o_stat.iter_done = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tare  <= '0;
            r_scale <= SCALE_W'(1) << SCALE_FRAC_BITS;
            r_cnt   <= '0;
        end else begin
            if (i_cmd.prep) begin
                if (w_is_tare) begin
                    r_cnt <= '0;
                end else if (w_is_cal) begin
                    r_cnt <= w_dzero ? '0 : CNT_W'(DIVD_W);
                end else begin
                    r_cnt <= CNT_W'(DELTA_W);
                end
            end else if (i_cmd.step) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (i_cmd.commit) begin
                if (w_is_tare) begin
                    r_tare <= r_raw;
                end else if (w_is_cal && !r_dzero) begin
                    r_scale <= w_scale_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act <= i_action;
            r_raw <= i_raw_sample[SAMPLE_BITS-1:0];
            r_ref <= i_reference_grams;
        end
        if (i_cmd.prep) begin
            r_mplier  <= w_dmag;
            r_mcand   <= w_smag;
            r_acc     <= '0;
            r_divisor <= w_dmag;
            r_rem     <= '0;
            r_quo     <= {w_rmag, {SCALE_FRAC_BITS{1'b0}}};
            r_dzero   <= w_dzero;
            r_neg     <= w_is_cal ? (r_ref[REF_W-1] != w_delta[DELTA_W-1])
                                  : (w_delta[DELTA_W-1] != r_scale[SCALE_W-1]);
        end else if (i_cmd.step) begin
            if (w_is_cal) begin
                if (!w_rsub[DELTA_W]) begin
                    r_rem <= w_rsub[DELTA_W-1:0];
                    r_quo <= {r_quo[DIVD_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_rsh[DELTA_W-1:0];
                    r_quo <= {r_quo[DIVD_W-2:0], 1'b0};
                end
            end else begin
                r_acc    <= (r_acc << 1) + (r_mplier[DELTA_W-1] ? PROD_W'(r_mcand) : '0);
                r_mplier <= r_mplier << 1;
            end
        end
        if (i_cmd.commit) begin
            if (w_is_tare) begin
                r_weight <= '0;
                r_status <= ST_TARED;
                r_sat    <= 1'b0;
            end else if (w_is_cal) begin
                r_weight <= '0;
                r_status <= r_dzero ? ST_REFUSED : ST_SCALED;
                r_sat    <= !r_dzero && w_dsat;
            end else begin
                r_weight <= w_weight;
                r_status <= ST_MEASURED;
                r_sat    <= w_msat;
            end
        end
    end

    assign o_weight_grams = r_weight;
    assign o_status       = r_status;
    assign o_saturated    = r_sat;

endmodule

`default_nettype wire

@@ hdl/lcts_ctrl.sv @@
// Controller: request sequencing, iteration control and result valid.
`default_nettype none

module lcts_ctrl
    import lcts_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_valid,
    output logic     o_stall,
    output logic     o_valid,
    input  wire      i_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: n_state = S_RUN;
            S_RUN: begin
                if (i_stat.iter_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.capture = i_valid;
            end
            S_PREP: o_cmd.prep = 1'b1;
            S_RUN:  o_cmd.step = !i_stat.iter_done;
            S_DONE: o_cmd.commit = w_slot_free;
            default: o_stall = 1'b1;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

@@ hdl/load_cell_tare_scale.sv @@
// Load cell tare and span calibration: top level.
// Input channel: i_valid / o_stall with action, raw converter word and reference
// weight. A request is taken while the block is idle, one at a time.
// Output channel: o_valid / i_stall with weight, status and saturation flag;
// exactly one result per request, held in an output register.
// An accepted request passes through the prep, run and done states; the result is
// written in done and o_valid follows from a register. In run, measure uses a
// shift-add multiplier, one delta bit per cycle, calibrate a restoring divider,
// one quotient bit per cycle; tare or a refused calibrate has no iterations.
// The next request is taken the cycle after the result is written.
// While a result waits in the output register a new request is still taken;
// it runs to completion and then holds until the receiver takes the old one.
// Reset (synchronous, active low) clears the tare offset to 0, sets the scale
// to 1.0 and empties the output register.
`default_nettype none

module load_cell_tare_scale
    import lcts_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_stall,
    input  wire  [1:0]                 i_action,
    input  wire  [RAW_W-1:0]           i_raw_sample,
    input  wire  signed [REF_W-1:0]    i_reference_grams,
    output logic                       o_valid,
    input  wire                        i_stall,
    output logic signed [WEIGHT_W-1:0] o_weight_grams,
    output logic [1:0]                 o_status,
    output logic                       o_saturated
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    lcts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    lcts_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_action          (i_action),
        .i_raw_sample      (i_raw_sample),
        .i_reference_grams (i_reference_grams),
        .o_weight_grams    (o_weight_grams),
        .o_status          (o_status),
        .o_saturated       (o_saturated)
    );

`ifndef ASSERT_OFF
    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> w_cmd.prep)
        else $error("accepted request not followed by prep");

    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_valid)
        else $error("commit did not raise result valid");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.commit))
        else $error("result valid without commit");

    a_weight_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_MEASURED) |-> (o_weight_grams == '0))
        else $error("non-measure result carries a weight");
`endif

endmodule

`default_nettype wire

@@ tb/lcts_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the load cell tare and scale block: predicts each request's result and compares.
module lcts_checker
    import lcts_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_req_valid,
    input  wire                        i_req_stall,
    input  wire  [1:0]                 i_req_action,
    input  wire  [RAW_W-1:0]           i_req_raw,
    input  wire  signed [REF_W-1:0]    i_req_ref,
    input  wire                        i_res_valid,
    input  wire                        i_res_stall,
    input  wire  signed [WEIGHT_W-1:0] i_res_weight,
    input  wire  [1:0]                 i_res_status,
    input  wire                        i_res_saturated,
    output int                         o_errors,
    output int                         o_outstanding,
    output int                         o_checked
);

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] weight;
        logic [1:0]                 status;
        logic                       saturated;
    } t_reading;

    t_reading                      pending_readings[$];
    logic signed [SAMPLE_BITS-1:0] tare_offset;
    logic signed [SCALE_W-1:0]     scale_factor;
    int                            fail_count = 0;
    int                            result_count = 0;

    task automatic predict_reading(input logic [1:0] act, input logic [RAW_W-1:0] raw_word,
                                   input logic signed [REF_W-1:0] ref_g);
        logic signed [SAMPLE_BITS-1:0] raw_s;
        logic signed [DELTA_W-1:0]     delta;
        logic [DELTA_W-1:0]            delta_mag;
        logic [SCALE_W-1:0]            scale_mag;
        logic [REF_W-1:0]              ref_mag;
        logic [PROD_W-1:0]             product;
        logic [MQ_W-1:0]               weight_mag;
        logic [MQ_W-1:0]               weight_lim;
        logic [DQ_W-1:0]               quot;
        logic [DQ_W-1:0]               quot_lim;
        logic                          neg;
        t_reading                      r;
        raw_s = raw_word[SAMPLE_BITS-1:0];
        delta = {raw_s[SAMPLE_BITS-1], raw_s} - {tare_offset[SAMPLE_BITS-1], tare_offset};
        delta_mag = delta[DELTA_W-1] ? -delta : delta;
        r = '0;
        case (act)
            ACT_TARE: begin
                tare_offset = raw_s;
                r.status = ST_TARED;
            end
            ACT_CALIB: begin
                if (delta == 0) begin
                    r.status = ST_REFUSED;
                end else begin
                    ref_mag = ref_g[REF_W-1] ? -ref_g : ref_g;
                    neg = ref_g[REF_W-1] ^ delta[DELTA_W-1];
                    quot = (DQ_W'(ref_mag) << SCALE_FRAC_BITS) / DQ_W'(delta_mag);
                    quot_lim = neg ? (DQ_W'(1) << (SCALE_W - 1))
                                   : (DQ_W'(1) << (SCALE_W - 1)) - 1;
                    if (quot > quot_lim) begin
                        quot = quot_lim;
                        r.saturated = 1'b1;
                    end
                    scale_factor = neg ? -quot[SCALE_W-1:0] : quot[SCALE_W-1:0];
                    r.status = ST_SCALED;
                end
            end
            default: begin
                // measure; the spare action code lands here too
                scale_mag = scale_factor[SCALE_W-1] ? -scale_factor : scale_factor;
                neg = delta[DELTA_W-1] ^ scale_factor[SCALE_W-1];
                product = PROD_W'(delta_mag) * PROD_W'(scale_mag);
                weight_mag = MQ_W'(product >> SCALE_FRAC_BITS);
                weight_lim = neg ? (MQ_W'(1) << (WEIGHT_W - 1))
                                 : (MQ_W'(1) << (WEIGHT_W - 1)) - 1;
                if (weight_mag > weight_lim) begin
                    weight_mag = weight_lim;
                    r.saturated = 1'b1;
                end
                r.weight = neg ? -weight_mag[WEIGHT_W-1:0] : weight_mag[WEIGHT_W-1:0];
                r.status = ST_MEASURED;
            end
        endcase
        pending_readings.push_back(r);
    endtask

    task automatic check_reading();
        t_reading exp_r;
        if (pending_readings.size() == 0) begin
            $error("result with no request outstanding: weight_grams %0d, status %0d",
                   i_res_weight, i_res_status);
            fail_count++;
        end else begin
            exp_r = pending_readings.pop_front();
            if (i_res_weight !== exp_r.weight) begin
                $error("weight_grams: expected %0d, got %0d", $signed(exp_r.weight),
                       i_res_weight);
                fail_count++;
            end
            if (i_res_status !== exp_r.status) begin
                $error("status: expected %0d, got %0d", exp_r.status, i_res_status);
                fail_count++;
            end
            if (i_res_saturated !== exp_r.saturated) begin
                $error("saturated: expected %0d, got %0d", exp_r.saturated, i_res_saturated);
                fail_count++;
            end
            result_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tare_offset = '0;
            scale_factor = SCALE_W'(1) << SCALE_FRAC_BITS;
            pending_readings.delete();
        end else begin
            if (i_res_valid && !i_res_stall) check_reading();
            if (i_req_valid && !i_req_stall) predict_reading(i_req_action, i_req_raw, i_req_ref);
        end
        o_outstanding <= pending_readings.size();
        o_errors      <= fail_count;
        o_checked     <= result_count;
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Testbench top: clock, reset, request and result traffic around the block, and the verdict.
module testbench;
    import lcts_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int HOLD_CYCLES    = 400;
    localparam int REQS_PER_PHASE = 310;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int TAIL_CYCLES    = 64;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       req_valid = 1'b0;
    logic                       req_stall;
    logic [1:0]                 req_action = ACT_MEASURE;
    logic [RAW_W-1:0]           req_raw = '0;
    logic signed [REF_W-1:0]    req_ref = '0;
    logic                       res_valid;
    logic                       res_stall = 1'b0;
    logic signed [WEIGHT_W-1:0] res_weight;
    logic [1:0]                 res_status;
    logic                       res_saturated;

    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    logic             hold_req = 1'b0;
    logic             hold_taken = 1'b0;
    int               hold_left = 0;
    logic [RAW_W-1:0] last_tare = '0;
    int               sent_count [0:3] = '{0, 0, 0, 0};
    int               fail_count;
    int               outstanding;
    int               checked;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    load_cell_tare_scale u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (req_valid),
        .o_stall           (req_stall),
        .i_action          (req_action),
        .i_raw_sample      (req_raw),
        .i_reference_grams (req_ref),
        .o_valid           (res_valid),
        .i_stall           (res_stall),
        .o_weight_grams    (res_weight),
        .o_status          (res_status),
        .o_saturated       (res_saturated)
    );

    lcts_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_req_valid     (req_valid),
        .i_req_stall     (req_stall),
        .i_req_action    (req_action),
        .i_req_raw       (req_raw),
        .i_req_ref       (req_ref),
        .i_res_valid     (res_valid),
        .i_res_stall     (res_stall),
        .i_res_weight    (res_weight),
        .i_res_status    (res_status),
        .i_res_saturated (res_saturated),
        .o_errors        (fail_count),
        .o_outstanding   (outstanding),
        .o_checked       (checked)
    );

    // receiver: random stall, plus one long hold-off on request
    always @(posedge clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            res_stall  <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end else begin
            res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    initial begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_request(input logic [1:0] act, input logic [RAW_W-1:0] raw_word,
                                input logic signed [REF_W-1:0] ref_g);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        req_action <= act;
        req_raw    <= raw_word;
        req_ref    <= ref_g;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        if (act == ACT_TARE) last_tare = raw_word;
        sent_count[act]++;
    endtask

    task automatic random_request();
        int                      pick;
        int                      span;
        logic [1:0]              act;
        logic [RAW_W-1:0]        raw_word;
        logic signed [REF_W-1:0] ref_g;
        pick = $urandom_range(0, 99);
        if (pick < 55) act = ACT_MEASURE;
        else if (pick < 68) act = ACT_TARE;
        else if (pick < 92) act = ACT_CALIB;
        else act = ACT_UNUSED;
        // mostly near the current tare so the scale stays usable
        span = $urandom_range(1, 23);
        raw_word = last_tare
                 + RAW_W'(int'($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1)));
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            raw_word = RAW_W'($urandom);
        end else if (pick == 2) begin
            raw_word = last_tare;
        end else if (pick == 3) begin
            case ($urandom_range(0, 3))
                0: raw_word = 24'h7FFFFF;
                1: raw_word = 24'h800000;
                2: raw_word = 24'h000000;
                default: raw_word = 24'hFFFFFF;
            endcase
        end
        span = $urandom_range(1, 23);
        if ($urandom_range(0, 9) < 3) ref_g = REF_W'($urandom);
        else ref_g = REF_W'(int'($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1)));
        send_request(act, raw_word, ref_g);
    endtask

    initial begin
        int guard;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(ACT_MEASURE, 24'h000000, 24'sd0);
        send_request(ACT_MEASURE, 24'h7FFFFF, 24'sh7FFFFF);
        send_request(ACT_MEASURE, 24'h800000, 24'sh800000);
        send_request(ACT_UNUSED,  24'h123456, 24'sd0);
        send_request(ACT_CALIB,   24'h000000, 24'sd1000);
        send_request(ACT_TARE,    24'h800000, 24'sd0);
        send_request(ACT_MEASURE, 24'h7FFFFF, 24'sd0);
        send_request(ACT_CALIB,   24'h800000, 24'sd500);
        send_request(ACT_TARE,    24'h000001, 24'sd0);
        send_request(ACT_CALIB,   24'h000000, 24'sh800000);
        send_request(ACT_MEASURE, 24'h7FFFFF, 24'sd0);
        send_request(ACT_MEASURE, 24'h800000, 24'sd0);
        send_request(ACT_CALIB,   24'h000002, 24'sh800000);
        send_request(ACT_MEASURE, 24'h7FFFFF, 24'sd0);
        send_request(ACT_MEASURE, 24'h000001, 24'sd0);
        send_request(ACT_CALIB,   24'h000006, 24'sd0);
        send_request(ACT_MEASURE, 24'hFFFFFF, 24'sd0);
        send_request(ACT_TARE,    24'h000000, 24'sd0);
        send_request(ACT_CALIB,   24'h800000, 24'sh7FFFFF);
        send_request(ACT_MEASURE, 24'h7FFFFF, 24'sd0);
        send_request(ACT_TARE,    24'h7FFFFF, 24'sd0);
        send_request(ACT_CALIB,   24'h800000, 24'sh7FFFFF);
        send_request(ACT_MEASURE, 24'h000000, 24'sd0);
        send_request(ACT_TARE,    24'h000000, 24'sd0);
        send_request(ACT_CALIB,   24'h0003E8, 24'sd1000);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 24;
                    recv_idle_pct <= 79;
                end
                1: begin
                    send_idle_pct = 79;
                    recv_idle_pct <= 24;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            for (int n = 0; n < REQS_PER_PHASE; n++) begin
                if (phase == 0 && n == 60) hold_req <= 1'b1;
                random_request();
            end
        end
        req_valid <= 1'b0;

        @(posedge clk);
        guard = 0;
        while (outstanding != 0 && guard < DRAIN_LIMIT) begin
            @(posedge clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Requests: %0d measure, %0d tare, %0d calibrate, %0d spare code; %0d checked.",
                 sent_count[ACT_MEASURE], sent_count[ACT_TARE], sent_count[ACT_CALIB],
                 sent_count[ACT_UNUSED], checked);
        $display("Idle mixes 24/79, 79/24 and none, with one %0d-cycle receiver hold-off.",
                 HOLD_CYCLES);
        if (fail_count == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
